// File: rtl/core/hi_lo_multiply_divide_unit_assert.svh
// ----------------------------------------------------------------------------
// HI/LO multiply/divide unit assertion macros
// Shared concurrent assertion forms used by the unit's controller.
// ----------------------------------------------------------------------------
`ifndef HI_LO_MULTIPLY_DIVIDE_UNIT_ASSERT_SVH
`define HI_LO_MULTIPLY_DIVIDE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLMDU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hlmdu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HLMDU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hlmdu: next-cycle check failed");

`endif

// File: rtl/core/hlmdu_pkg.sv
// ----------------------------------------------------------------------------
// HI/LO multiply/divide unit package
// Operation codes, beat payload types and controller command types.
// ----------------------------------------------------------------------------
`default_nettype none

package hlmdu_pkg;

    localparam int WORD_W = 32;
    localparam int REG_W  = 5;
    localparam int OP_W   = 3;
    localparam int CNT_W  = 5;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_W - 1);

    localparam logic [OP_W-1:0] OP_MULT  = 3'd0;
    localparam logic [OP_W-1:0] OP_MULTU = 3'd1;
    localparam logic [OP_W-1:0] OP_DIV   = 3'd2;
    localparam logic [OP_W-1:0] OP_DIVU  = 3'd3;
    localparam logic [OP_W-1:0] OP_MTHI  = 3'd4;
    localparam logic [OP_W-1:0] OP_MTLO  = 3'd5;
    localparam logic [OP_W-1:0] OP_MFHI  = 3'd6;
    localparam logic [OP_W-1:0] OP_MFLO  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [WORD_W-1:0] first_operand;
        logic [WORD_W-1:0] second_operand;
        logic [REG_W-1:0]  dest_register;
    } in_beat_t;

    typedef struct packed {
        logic              write_enable;
        logic [REG_W-1:0]  write_register;
        logic [WORD_W-1:0] write_value;
        logic [WORD_W-1:0] hi_value;
        logic [WORD_W-1:0] lo_value;
    } out_beat_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic finish;
    } cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/hlmdu_ctrl.sv
// ----------------------------------------------------------------------------
// HI/LO multiply/divide unit controller
// Sequences accept, multiply, divide iterations and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hi_lo_multiply_divide_unit_assert.svh"

module hlmdu_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [hlmdu_pkg::OP_W-1:0]  s_operation,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output hlmdu_pkg::cmd_t                  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t                        state_reg, state_next;
    logic [hlmdu_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          accept;
    logic                          out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.load     = accept;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next = '0;
                    case (s_operation)
                        hlmdu_pkg::OP_MULT, hlmdu_pkg::OP_MULTU: state_next = ST_MULT;
                        hlmdu_pkg::OP_DIV, hlmdu_pkg::OP_DIVU:   state_next = ST_DIVIDE;
                        default:                                 state_next = ST_FINISH;
                    endcase
                end
            end
            ST_MULT: begin
                cmd.mul    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == hlmdu_pkg::DIV_LAST) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `HLMDU_ASSERT_NEXT(a_div_start, aclk, aresetn,
        accept && (s_operation == hlmdu_pkg::OP_DIV || s_operation == hlmdu_pkg::OP_DIVU),
        state_reg == ST_DIVIDE && cnt_reg == '0)
    `HLMDU_ASSERT_NEXT(a_div_end, aclk, aresetn,
        state_reg == ST_DIVIDE && cnt_reg == hlmdu_pkg::DIV_LAST, state_reg == ST_FINISH)
    `HLMDU_ASSERT_NEXT(a_finish_holds, aclk, aresetn,
        state_reg == ST_FINISH && m_valid_reg && !m_ready, state_reg == ST_FINISH)
    `HLMDU_ASSERT_NEXT(a_finish_shows, aclk, aresetn, cmd.finish, m_valid_reg && s_ready)

endmodule

`default_nettype wire

// File: rtl/core/hlmdu_datapath.sv
// ----------------------------------------------------------------------------
// HI/LO multiply/divide unit datapath
// Operand registers, multiplier, radix-2 divider, HI/LO and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hlmdu_datapath (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire hlmdu_pkg::cmd_t       cmd,
    input  wire hlmdu_pkg::in_beat_t   in_beat,
    output hlmdu_pkg::out_beat_t       out_beat
);

    localparam int W = hlmdu_pkg::WORD_W;

    logic [hlmdu_pkg::OP_W-1:0]  op_reg;
    logic [W-1:0]                a_reg;
    logic [W-1:0]                b_reg;
    logic [hlmdu_pkg::REG_W-1:0] rd_reg;
    logic [2*W-1:0]              prod_reg;
    logic [W-1:0]                quo_reg, quo_next;
    logic [W-1:0]                rem_reg, rem_next;
    logic [W-1:0]                dvs_reg;
    logic [W-1:0]                hi_reg, hi_next;
    logic [W-1:0]                lo_reg, lo_next;
    hlmdu_pkg::out_beat_t        out_reg, out_next;

    logic                        signed_div;
    logic [W:0]                  shifted;
    logic [W:0]                  trial;
    logic                        a_neg;
    logic                        b_neg;

    assign signed_div = (in_beat.operation == hlmdu_pkg::OP_DIV);
    assign a_neg      = a_reg[W-1];
    assign b_neg      = b_reg[W-1];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_beat.operation;
            a_reg   <= in_beat.first_operand;
            b_reg   <= in_beat.second_operand;
            rd_reg  <= in_beat.dest_register;
            rem_reg <= '0;
            quo_reg <= (signed_div && in_beat.first_operand[W-1])
                       ? (W'(0) - in_beat.first_operand) : in_beat.first_operand;
            dvs_reg <= (signed_div && in_beat.second_operand[W-1])
                       ? (W'(0) - in_beat.second_operand) : in_beat.second_operand;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.mul) begin
            prod_reg <= a_reg * b_reg;
        end
        if (cmd.finish) begin
            out_reg <= out_next;
        end
    end

    always_comb begin
        shifted = {rem_reg, quo_reg[W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        if (!trial[W]) begin
            rem_next = trial[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end else begin
            rem_next = shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    always_comb begin
        hi_next  = hi_reg;
        lo_next  = lo_reg;
        out_next = '0;
        case (op_reg)
            hlmdu_pkg::OP_MULT: begin
                hi_next = prod_reg[2*W-1:W] - (a_neg ? b_reg : W'(0))
                          - (b_neg ? a_reg : W'(0));
                lo_next = prod_reg[W-1:0];
            end
            hlmdu_pkg::OP_MULTU: begin
                hi_next = prod_reg[2*W-1:W];
                lo_next = prod_reg[W-1:0];
            end
            hlmdu_pkg::OP_DIV: begin
                hi_next = a_neg ? (W'(0) - rem_reg) : rem_reg;
                lo_next = (a_neg != b_neg) ? (W'(0) - quo_reg) : quo_reg;
            end
            hlmdu_pkg::OP_DIVU: begin
                hi_next = rem_reg;
                lo_next = quo_reg;
            end
            hlmdu_pkg::OP_MTHI: begin
                hi_next = a_reg;
            end
            hlmdu_pkg::OP_MTLO: begin
                lo_next = a_reg;
            end
            hlmdu_pkg::OP_MFHI: begin
                out_next.write_enable   = 1'b1;
                out_next.write_register = rd_reg;
                out_next.write_value    = hi_reg;
            end
            hlmdu_pkg::OP_MFLO: begin
                out_next.write_enable   = 1'b1;
                out_next.write_register = rd_reg;
                out_next.write_value    = lo_reg;
            end
            default: begin
                hi_next = hi_reg;
            end
        endcase
        out_next.hi_value = hi_next;
        out_next.lo_value = lo_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg <= '0;
            lo_reg <= '0;
        end else if (cmd.finish) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign out_beat = out_reg;

endmodule

`default_nettype wire

// File: rtl/core/hi_lo_multiply_divide_unit.sv
// ----------------------------------------------------------------------------
// HI/LO multiply/divide unit
// Keeps the HI and LO registers and runs multiply, divide and move operations.
// ----------------------------------------------------------------------------
// One beat on the s_ channel carries an operation, two 32-bit operands and a
// destination register number. Every accepted beat yields exactly one beat on
// the m_ channel with the write-back request and the HI and LO contents after
// the operation.
// Moves go from acceptance straight to the finish state; multiplies pass the
// multiply state first and divides a radix-2 restoring loop that retires one
// quotient bit per cycle for 32 bits; that loop sets the divide rate.
// The unit works on one operation at a time; s_ready is high only while it
// is idle. A finished result waits in the output register, so the next beat
// can be accepted while the previous result is still unclaimed.
// If the receiver stalls, the unit holds its next result internally and does
// not update HI or LO until the output register frees up.
// Reset (aresetn low, synchronous) clears HI, LO, the controller state and
// m_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module hi_lo_multiply_divide_unit (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire hlmdu_pkg::in_beat_t   s_payload,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output hlmdu_pkg::out_beat_t       m_payload
);

    hlmdu_pkg::cmd_t cmd;

    hlmdu_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_payload.operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd)
    );

    hlmdu_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_beat  (s_payload),
        .out_beat (m_payload)
    );

endmodule

`default_nettype wire
